>>> design/crtc_pkg.sv
// Shared types, register numbers and decode helpers for the CRT controller register file.
package crtc_pkg;

    localparam int unsigned NUM_TIMING = 9;
    localparam int unsigned SLOT_W = $clog2(NUM_TIMING);

    typedef enum logic [1:0] {
        CMD_WR_INDEX = 2'd0,
        CMD_RD_INDEX = 2'd1,
        CMD_WR_DATA  = 2'd2,
        CMD_RD_DATA  = 2'd3
    } cmd_t;

    localparam logic [7:0] REG_MAX_SCAN     = 8'd9;
    localparam logic [7:0] REG_CURSOR_START = 8'd10;
    localparam logic [7:0] REG_CURSOR_END   = 8'd11;
    localparam logic [7:0] REG_START_HI     = 8'd12;
    localparam logic [7:0] REG_START_LO     = 8'd13;
    localparam logic [7:0] REG_CURSOR_HI    = 8'd14;
    localparam logic [7:0] REG_CURSOR_LO    = 8'd15;

    localparam logic [7:0] ILLEGAL_READ = 8'hFF;
    localparam logic [1:0] CURSOR_OFF_CODE = 2'b01;

    // controller to datapath
    typedef struct packed {
        logic load;
    } dp_cmd_t;

    function automatic logic is_timing(input logic [7:0] idx);
        return (idx <= 8'd7) || (idx == REG_MAX_SCAN);
    endfunction

    function automatic logic [SLOT_W-1:0] timing_slot(input logic [7:0] idx);
        logic [SLOT_W-1:0] slot;
        slot = (idx == REG_MAX_SCAN) ? SLOT_W'(NUM_TIMING - 1) : idx[SLOT_W-1:0];
        return slot;
    endfunction

    function automatic logic is_geometry(input logic [7:0] idx);
        return (idx == 8'd0) || (idx == 8'd1) || (idx == 8'd4) || (idx == 8'd5)
            || (idx == 8'd6) || (idx == REG_MAX_SCAN);
    endfunction

endpackage

>>> design/crtc_ctrl.sv
// Handshake controller: tracks whether the output register holds an unclaimed item.
module crtc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output crtc_pkg::dp_cmd_t  dp_cmd
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready      = (state_reg == ST_EMPTY) || m_tready;
    assign m_tvalid      = (state_reg == ST_FULL);
    assign accept        = s_tvalid && s_tready;
    assign dp_cmd.load   = accept;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (m_tready && !accept)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !dp_cmd.load)
        else $error("pending result overwritten");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !s_tvalid) |=> !m_tvalid)
        else $error("result repeated after being taken");
`endif

endmodule

>>> design/crtc_dpath.sv
// Register bank, read mux and output register of the CRT controller register file.
module crtc_dpath
(
    input  logic               clk,
    input  logic               rst_n,
    input  crtc_pkg::dp_cmd_t  dp_cmd,
    input  logic [1:0]         cmd,
    input  logic [7:0]         write_data,
    output logic [7:0]         read_data,
    output logic               resize_request,
    output logic               illegal_index,
    output logic [15:0]        display_start_out,
    output logic [15:0]        cursor_address_out,
    output logic [4:0]         cursor_first_line,
    output logic [4:0]         cursor_last_line,
    output logic               cursor_on
);

    logic [7:0]  index_reg, index_next;
    logic [7:0]  timing_reg [crtc_pkg::NUM_TIMING];
    logic [15:0] start_reg, start_next;
    logic [15:0] cursor_reg, cursor_next;
    logic [4:0]  cur_first_reg, cur_first_next;
    logic [4:0]  cur_last_reg, cur_last_next;
    logic        cur_on_reg, cur_on_next;
    logic [7:0]  rd_reg, rd_next;
    logic        resize_reg, resize_next;
    logic        illegal_reg, illegal_next;
    logic        timing_wr;

    logic                        sel_timing;
    logic [crtc_pkg::SLOT_W-1:0] slot;
    logic [7:0]                  timing_rd;
    crtc_pkg::cmd_t              op;

    assign op         = crtc_pkg::cmd_t'(cmd);
    assign sel_timing = crtc_pkg::is_timing(index_reg);
    assign slot       = crtc_pkg::timing_slot(index_reg);
    assign timing_rd  = timing_reg[slot];

    always_comb
    begin
        index_next     = index_reg;
        start_next     = start_reg;
        cursor_next    = cursor_reg;
        cur_first_next = cur_first_reg;
        cur_last_next  = cur_last_reg;
        cur_on_next    = cur_on_reg;
        rd_next        = 8'h00;
        resize_next    = 1'b0;
        illegal_next   = 1'b0;
        timing_wr      = 1'b0;
        case (op)
            crtc_pkg::CMD_WR_INDEX:
            begin
                index_next = write_data;
            end
            crtc_pkg::CMD_RD_INDEX:
            begin
                rd_next = index_reg;
            end
            crtc_pkg::CMD_WR_DATA:
            begin
                if (sel_timing)
                begin
                    timing_wr   = 1'b1;
                    resize_next = crtc_pkg::is_geometry(index_reg) && (timing_rd != write_data);
                end
                else
                begin
                    case (index_reg)
                        crtc_pkg::REG_CURSOR_START:
                        begin
                            cur_first_next = write_data[4:0];
                            cur_on_next    = (write_data[6:5] != crtc_pkg::CURSOR_OFF_CODE);
                        end
                        crtc_pkg::REG_CURSOR_END: cur_last_next      = write_data[4:0];
                        crtc_pkg::REG_START_HI:   start_next[15:8]  = write_data;
                        crtc_pkg::REG_START_LO:   start_next[7:0]   = write_data;
                        crtc_pkg::REG_CURSOR_HI:  cursor_next[15:8] = write_data;
                        crtc_pkg::REG_CURSOR_LO:  cursor_next[7:0]  = write_data;
                        default:                  illegal_next      = 1'b1;
                    endcase
                end
            end
            crtc_pkg::CMD_RD_DATA:
            begin
                if (sel_timing)
                begin
                    rd_next = timing_rd;
                end
                else
                begin
                    case (index_reg)
                        crtc_pkg::REG_START_HI:  rd_next = start_reg[15:8];
                        crtc_pkg::REG_START_LO:  rd_next = start_reg[7:0];
                        crtc_pkg::REG_CURSOR_HI: rd_next = cursor_reg[15:8];
                        crtc_pkg::REG_CURSOR_LO: rd_next = cursor_reg[7:0];
                        default:
                        begin
                            rd_next      = crtc_pkg::ILLEGAL_READ;
                            illegal_next = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                rd_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            start_reg     <= '0;
            cursor_reg    <= '0;
            cur_first_reg <= '0;
            cur_last_reg  <= '0;
            cur_on_reg    <= 1'b0;
            for (int i = 0; i < int'(crtc_pkg::NUM_TIMING); i++)
            begin
                timing_reg[i] <= '0;
            end
        end
        else if (dp_cmd.load)
        begin
            index_reg     <= index_next;
            start_reg     <= start_next;
            cursor_reg    <= cursor_next;
            cur_first_reg <= cur_first_next;
            cur_last_reg  <= cur_last_next;
            cur_on_reg    <= cur_on_next;
            if (timing_wr)
            begin
                timing_reg[slot] <= write_data;
            end
        end
    end

    // result fields, no reset needed
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            rd_reg      <= rd_next;
            resize_reg  <= resize_next;
            illegal_reg <= illegal_next;
        end
    end

    assign read_data          = rd_reg;
    assign resize_request     = resize_reg;
    assign illegal_index      = illegal_reg;
    assign display_start_out  = start_reg;
    assign cursor_address_out = cursor_reg;
    assign cursor_first_line  = cur_first_reg;
    assign cursor_last_line   = cur_last_reg;
    assign cursor_on          = cur_on_reg;

`ifndef SYNTHESIS
    a_index_write: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.load && op == crtc_pkg::CMD_WR_INDEX) |=> index_reg == $past(write_data))
        else $error("index register not updated");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load |=> !(resize_reg && illegal_reg))
        else $error("resize and illegal flagged together");

    a_index_access_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.load && (op == crtc_pkg::CMD_WR_INDEX || op == crtc_pkg::CMD_RD_INDEX))
        |=> (!resize_reg && !illegal_reg))
        else $error("flag raised on index access");
`endif

endmodule

>>> design/crtc_index_data_register_file.sv
// Top level of the CRT controller index/data register file.
// Takes one bus access per item (index write, index read, data write, data read) and
// returns one result item for each. An item may be accepted every clock cycle unless a
// result is pending while m_tready is low; the result appears from the output register in
// the cycle after acceptance and carries the read byte, the resize and illegal-index flags,
// and the display start, cursor address and cursor shape as they stand after the access.
// One output register; a new item is taken in the same cycle the pending result is taken.
module crtc_index_data_register_file
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] write_data
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] resize_request, [9] illegal_index, [25:10] display_start_out,
    // [41:26] cursor_address_out, [46:42] cursor_first_line, [51:47] cursor_last_line,
    // [52] cursor_on, [55:53] zero
    output logic [55:0] m_tdata
);

    crtc_pkg::dp_cmd_t dp_cmd;

    logic [7:0]  read_data;
    logic        resize_request;
    logic        illegal_index;
    logic [15:0] display_start_out;
    logic [15:0] cursor_address_out;
    logic [4:0]  cursor_first_line;
    logic [4:0]  cursor_last_line;
    logic        cursor_on;

    crtc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    crtc_dpath u_dpath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .dp_cmd             (dp_cmd),
        .cmd                (s_tuser),
        .write_data         (s_tdata),
        .read_data          (read_data),
        .resize_request     (resize_request),
        .illegal_index      (illegal_index),
        .display_start_out  (display_start_out),
        .cursor_address_out (cursor_address_out),
        .cursor_first_line  (cursor_first_line),
        .cursor_last_line   (cursor_last_line),
        .cursor_on          (cursor_on)
    );

    assign m_tdata = {3'b000, cursor_on, cursor_last_line, cursor_first_line,
                      cursor_address_out, display_start_out, illegal_index,
                      resize_request, read_data};

endmodule

>>> tb/tb_crtc_index_data_register_file.sv
// Self-checking testbench for the CRT controller index/data register file.
`timescale 1ns / 100ps

module tb_crtc_index_data_register_file;

    localparam logic [7:0] REG_H_TOTAL      = 8'd0;
    localparam logic [7:0] REG_H_DISPLAYED  = 8'd1;
    localparam logic [7:0] REG_V_TOTAL      = 8'd4;
    localparam logic [7:0] REG_V_ADJUST     = 8'd5;
    localparam logic [7:0] REG_V_DISPLAYED  = 8'd6;
    localparam logic [7:0] REG_LAST_PLAIN   = 8'd7;
    localparam logic [7:0] REG_UNUSED       = 8'd8;
    localparam logic [7:0] REG_FIRST_ABSENT = 8'd16;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  spare;
        logic        cursor_on;
        logic [4:0]  cursor_last_line;
        logic [4:0]  cursor_first_line;
        logic [15:0] cursor_address;
        logic [15:0] disp_start;
        logic        illegal_index;
        logic        resize_request;
        logic [7:0]  read_data;
    } crtc_result_t;

    class crtc_scoreboard;
        logic [7:0]   sel_index;
        logic [7:0]   timing[crtc_pkg::NUM_TIMING];
        logic [15:0]  start_addr;
        logic [15:0]  cursor_addr;
        logic [4:0]   first_line;
        logic [4:0]   last_line;
        logic         cursor_en;
        crtc_result_t pending[$];
        int           errors;

        function new();
            sel_index = '0;
            foreach (timing[i])
                timing[i] = '0;
            start_addr  = '0;
            cursor_addr = '0;
            first_line  = '0;
            last_line   = '0;
            cursor_en   = 1'b0;
            errors      = 0;
        endfunction

        function int slot_of(input logic [7:0] idx);
            if (idx <= REG_LAST_PLAIN)
                return int'(idx);
            if (idx == crtc_pkg::REG_MAX_SCAN)
                return int'(crtc_pkg::NUM_TIMING) - 1;
            return -1;
        endfunction

        function bit sets_geometry(input logic [7:0] idx);
            return idx == REG_H_TOTAL || idx == REG_H_DISPLAYED || idx == REG_V_TOTAL
                || idx == REG_V_ADJUST || idx == REG_V_DISPLAYED
                || idx == crtc_pkg::REG_MAX_SCAN;
        endfunction

        function void note_access(input crtc_pkg::cmd_t cmd, input logic [7:0] wd);
            crtc_result_t r;
            int           slot;
            r    = '0;
            slot = slot_of(sel_index);
            case (cmd)
                crtc_pkg::CMD_WR_INDEX: sel_index = wd;
                crtc_pkg::CMD_RD_INDEX: r.read_data = sel_index;
                crtc_pkg::CMD_WR_DATA:
                    if (slot >= 0)
                    begin
                        r.resize_request = sets_geometry(sel_index) && timing[slot] != wd;
                        timing[slot] = wd;
                    end
                    else
                    begin
                        case (sel_index)
                            crtc_pkg::REG_CURSOR_START:
                            begin
                                first_line = wd[4:0];
                                cursor_en  = wd[6:5] != crtc_pkg::CURSOR_OFF_CODE;
                            end
                            crtc_pkg::REG_CURSOR_END: last_line = wd[4:0];
                            crtc_pkg::REG_START_HI:   start_addr[15:8] = wd;
                            crtc_pkg::REG_START_LO:   start_addr[7:0] = wd;
                            crtc_pkg::REG_CURSOR_HI:  cursor_addr[15:8] = wd;
                            crtc_pkg::REG_CURSOR_LO:  cursor_addr[7:0] = wd;
                            default:                  r.illegal_index = 1'b1;
                        endcase
                    end
                default:
                    if (slot >= 0)
                        r.read_data = timing[slot];
                    else
                    begin
                        case (sel_index)
                            crtc_pkg::REG_START_HI:  r.read_data = start_addr[15:8];
                            crtc_pkg::REG_START_LO:  r.read_data = start_addr[7:0];
                            crtc_pkg::REG_CURSOR_HI: r.read_data = cursor_addr[15:8];
                            crtc_pkg::REG_CURSOR_LO: r.read_data = cursor_addr[7:0];
                            default:
                            begin
                                r.read_data     = crtc_pkg::ILLEGAL_READ;
                                r.illegal_index = 1'b1;
                            end
                        endcase
                    end
            endcase
            r.disp_start        = start_addr;
            r.cursor_address    = cursor_addr;
            r.cursor_first_line = first_line;
            r.cursor_last_line  = last_line;
            r.cursor_on         = cursor_en;
            pending.push_back(r);
        endfunction

        function void compare(input string field, input logic [15:0] want,
                              input logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [55:0] raw);
            crtc_result_t got;
            crtc_result_t want;
            got = raw;
            if (pending.size() == 0)
            begin
                $error("result item %h with nothing outstanding", raw);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare("read_data", 16'(want.read_data), 16'(got.read_data));
            compare("resize_request", 16'(want.resize_request), 16'(got.resize_request));
            compare("illegal_index", 16'(want.illegal_index), 16'(got.illegal_index));
            compare("display_start_out", want.disp_start, got.disp_start);
            compare("cursor_address_out", want.cursor_address, got.cursor_address);
            compare("cursor_first_line", 16'(want.cursor_first_line),
                    16'(got.cursor_first_line));
            compare("cursor_last_line", 16'(want.cursor_last_line),
                    16'(got.cursor_last_line));
            compare("cursor_on", 16'(want.cursor_on), 16'(got.cursor_on));
            compare("spare", 16'(want.spare), 16'(got.spare));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        calm = 1'b0;
    int unsigned cycles = 0;

    crtc_scoreboard sb = new();

    crtc_index_data_register_file i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= calm || ($urandom_range(99) >= 9);
    end

    task automatic send_item(input crtc_pkg::cmd_t cmd, input logic [7:0] wd);
        if (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= wd;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_access(cmd, wd);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    task automatic run_directed();
        send_item(crtc_pkg::CMD_RD_INDEX, 8'h00);
        send_item(crtc_pkg::CMD_RD_DATA, 8'h00);
        send_item(crtc_pkg::CMD_WR_DATA, 8'h00);   // same value, no resize
        send_item(crtc_pkg::CMD_WR_DATA, 8'hFF);
        send_item(crtc_pkg::CMD_RD_DATA, 8'h00);
        send_item(crtc_pkg::CMD_WR_INDEX, REG_LAST_PLAIN);
        send_item(crtc_pkg::CMD_WR_DATA, 8'h5A);
        send_item(crtc_pkg::CMD_WR_INDEX, crtc_pkg::REG_MAX_SCAN);
        send_item(crtc_pkg::CMD_WR_DATA, 8'h1F);
        send_item(crtc_pkg::CMD_RD_DATA, 8'h00);
        send_item(crtc_pkg::CMD_WR_INDEX, REG_UNUSED);
        send_item(crtc_pkg::CMD_WR_DATA, 8'h33);
        send_item(crtc_pkg::CMD_RD_DATA, 8'h00);
        send_item(crtc_pkg::CMD_WR_INDEX, crtc_pkg::REG_CURSOR_START);
        send_item(crtc_pkg::CMD_WR_DATA, 8'h20);   // cursor off code
        send_item(crtc_pkg::CMD_WR_DATA, 8'hDF);
        send_item(crtc_pkg::CMD_RD_DATA, 8'h00);   // write-only
        send_item(crtc_pkg::CMD_WR_INDEX, crtc_pkg::REG_CURSOR_END);
        send_item(crtc_pkg::CMD_WR_DATA, 8'hFF);
        send_item(crtc_pkg::CMD_WR_INDEX, crtc_pkg::REG_START_HI);
        send_item(crtc_pkg::CMD_WR_DATA, 8'hAA);
        send_item(crtc_pkg::CMD_RD_DATA, 8'h00);
        send_item(crtc_pkg::CMD_WR_INDEX, crtc_pkg::REG_CURSOR_LO);
        send_item(crtc_pkg::CMD_WR_DATA, 8'h01);
        send_item(crtc_pkg::CMD_RD_DATA, 8'h00);
        send_item(crtc_pkg::CMD_WR_INDEX, REG_FIRST_ABSENT);
        send_item(crtc_pkg::CMD_WR_DATA, 8'h00);
        send_item(crtc_pkg::CMD_WR_INDEX, 8'hFF);
        send_item(crtc_pkg::CMD_RD_INDEX, 8'h00);
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned count;
        int unsigned accesses;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [7:0]  prev;
        count = 0;
        prev  = '0;
        while (count < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(crtc_pkg::cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
                count++;
            end
            else
            begin
                idx = ($urandom_range(99) < 85) ? 8'($urandom_range(15))
                                                : 8'($urandom_range(255));
                send_item(crtc_pkg::CMD_WR_INDEX, idx);
                accesses = $urandom_range(1, 3);
                count += accesses + 1;
                repeat (accesses)
                begin
                    case ($urandom_range(9))
                        0:       val = 8'h00;
                        1:       val = 8'hFF;
                        2, 3:    val = prev;   // rewrite with the held value
                        default: val = 8'($urandom_range(255));
                    endcase
                    if ($urandom_range(1) == 0)
                    begin
                        send_item(crtc_pkg::CMD_WR_DATA, val);
                        prev = val;
                    end
                    else
                        send_item(crtc_pkg::CMD_RD_DATA, 8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        drain();
        run_random(600);
        calm <= 1'b1;
        run_random(300);
        calm <= 1'b0;
        drain();
        run_random(500);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
        repeat (4)
            @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
design/crtc_pkg.sv
design/crtc_ctrl.sv
design/crtc_dpath.sv
design/crtc_index_data_register_file.sv
tb/tb_crtc_index_data_register_file.sv
